@@ hdl/bpuck_pkg.sv @@
// ----------------------------------------------------------------------------
// bpuck_pkg
// Shared types, codes and mask helpers of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package bpuck_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic [CFG_AW-1:0] {
        REG_BPP      = 3'd0,
        REG_COMP     = 3'd1,
        REG_RED_MASK = 3'd2,
        REG_GRN_MASK = 3'd3,
        REG_BLU_MASK = 3'd4,
        REG_KEY_EN   = 3'd5
    } cfg_reg_t;

    localparam logic       CMD_LOAD    = 1'b0;
    localparam logic       CMD_CONVERT = 1'b1;

    localparam logic [5:0] BPP_1  = 6'd1;
    localparam logic [5:0] BPP_4  = 6'd4;
    localparam logic [5:0] BPP_8  = 6'd8;
    localparam logic [5:0] BPP_16 = 6'd16;
    localparam logic [5:0] BPP_24 = 6'd24;
    localparam logic [5:0] BPP_32 = 6'd32;

    localparam logic [3:0] COMP_PLAIN    = 4'd0;
    localparam logic [3:0] COMP_BITFIELD = 4'd3;

    typedef struct packed {
        logic [31:0] mask;
        logic [4:0]  low;
        logic [5:0]  span;
    } chan_fmt_t;

    typedef struct packed {
        logic [5:0] bpp;
        logic [3:0] comp;
        chan_fmt_t  red;
        chan_fmt_t  green;
        chan_fmt_t  blue;
        logic       key_en;
    } cfg_t;

    localparam chan_fmt_t FMT_565_R = '{mask: 32'h0000_f800, low: 5'd11, span: 6'd5};
    localparam chan_fmt_t FMT_565_G = '{mask: 32'h0000_07e0, low: 5'd5,  span: 6'd6};
    localparam chan_fmt_t FMT_565_B = '{mask: 32'h0000_001f, low: 5'd0,  span: 6'd5};
    localparam chan_fmt_t FMT_888_R = '{mask: 32'h00ff_0000, low: 5'd16, span: 6'd8};
    localparam chan_fmt_t FMT_888_G = '{mask: 32'h0000_ff00, low: 5'd8,  span: 6'd8};
    localparam chan_fmt_t FMT_888_B = '{mask: 32'h0000_00ff, low: 5'd0,  span: 6'd8};

    function automatic logic [4:0] mask_low(input logic [31:0] m);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (m[i])
                r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [4:0] mask_high(input logic [31:0] m);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
                r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [5:0] mask_span(input logic [31:0] m);
        return 6'(mask_high(m)) - 6'(mask_low(m)) + 6'd1;
    endfunction

endpackage

@@ hdl/bpuck_ram.sv @@
// ----------------------------------------------------------------------------
// bpuck_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpuck_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bpuck_cfg.sv @@
// ----------------------------------------------------------------------------
// bpuck_cfg
// Configuration registers; mask position and width are decoded on write.
// ----------------------------------------------------------------------------
module bpuck_cfg
    import bpuck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output cfg_t              cfg
);

    logic [5:0] bpp_reg;
    logic [3:0] comp_reg;
    chan_fmt_t  red_fmt_reg;
    chan_fmt_t  grn_fmt_reg;
    chan_fmt_t  blu_fmt_reg;
    logic       key_en_reg;
    chan_fmt_t  wr_fmt;

    assign wr_fmt = '{mask: cfg_wdata, low: mask_low(cfg_wdata), span: mask_span(cfg_wdata)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= BPP_8;
            comp_reg    <= COMP_PLAIN;
            red_fmt_reg <= '0;
            grn_fmt_reg <= '0;
            blu_fmt_reg <= '0;
            key_en_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_BPP:      bpp_reg     <= cfg_wdata[5:0];
                REG_COMP:     comp_reg    <= cfg_wdata[3:0];
                REG_RED_MASK: red_fmt_reg <= wr_fmt;
                REG_GRN_MASK: grn_fmt_reg <= wr_fmt;
                REG_BLU_MASK: blu_fmt_reg <= wr_fmt;
                REG_KEY_EN:   key_en_reg  <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    assign cfg = '{bpp: bpp_reg, comp: comp_reg, red: red_fmt_reg, green: grn_fmt_reg,
                   blue: blu_fmt_reg, key_en: key_en_reg};

endmodule

@@ hdl/bitmap_pixel_unpack_color_key_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_pixel_unpack_color_key_core
// Raw bitmap pixel to 8-bit RGB with palette, bitfield masks and color key.
// ----------------------------------------------------------------------------
// The core takes one item per clock while s_axis_tready is high; the result
// of a convert item leaves from the output register, and load items write
// the palette and return nothing. Four register stages do the work: input
// register, format decode with palette access, mask shift, then width
// scaling, key compare and the output register. The palette is one RAM with
// one write and one read port, used as an item leaves the input register,
// so loads and reads stay in order. Palette entries have no reset and must
// be loaded before they are used. tready drops only when all four stages
// hold items and the output is not taken.
module bitmap_pixel_unpack_color_key_core
    import bpuck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] pixel_word, [34:32] subpixel_index, [42:35] palette_slot,
    // [50:43] palette_red, [58:51] palette_green, [66:59] palette_blue, zeros above
    input  logic [71:0]       s_axis_tdata,
    // [0] command
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [23:0]       m_axis_tdata,
    // [0] write_enable, [1] status
    output logic [1:0]        m_axis_tuser
);

    cfg_t cfg;

    bpuck_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    function automatic logic [7:0] scale8(input logic [31:0] base, input logic [5:0] span);
        logic [31:0] t;
        if (span < 6'd8)
            t = base << (6'd8 - span);
        else
            t = base >> (span - 6'd8);
        return t[7:0];
    endfunction

    // stage valids and handshake chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic ready2, ready3, ready4;

    assign ready4        = !s4_valid_reg || m_axis_tready;
    assign ready3        = !s3_valid_reg || ready4;
    assign ready2        = !s2_valid_reg || ready3;
    assign s_axis_tready = !s1_valid_reg || ready2;

    // stage 1 payload
    logic        s1_cmd_reg;
    logic [31:0] s1_word_reg;
    logic [2:0]  s1_sub_reg;
    logic [7:0]  s1_slot_reg;
    logic [23:0] s1_rgb_reg;

    // stage 1 decode
    logic        bitfield, comp_ok, depth_ok, pal_mode;
    logic [31:0] c_word;
    logic [7:0]  byte0, pal_idx;
    chan_fmt_t   fmt_r, fmt_g, fmt_b;
    logic        ram_we, ram_re;
    logic [23:0] ram_rdata;

    assign byte0    = s1_word_reg[7:0];
    assign bitfield = (cfg.comp == COMP_BITFIELD);
    assign comp_ok  = (cfg.comp == COMP_PLAIN) || bitfield;
    assign pal_mode = (cfg.bpp == BPP_1) || (cfg.bpp == BPP_4) || (cfg.bpp == BPP_8);
    assign depth_ok = pal_mode || (cfg.bpp == BPP_16) || (cfg.bpp == BPP_24)
                      || (cfg.bpp == BPP_32);

    always_comb
    begin
        priority if (cfg.bpp == BPP_16)
            c_word = {16'd0, s1_word_reg[15:0]};
        else if (cfg.bpp == BPP_24)
            c_word = {8'd0, s1_word_reg[23:0]};
        else
            c_word = s1_word_reg;

        priority if (bitfield)
        begin
            fmt_r = cfg.red;
            fmt_g = cfg.green;
            fmt_b = cfg.blue;
        end
        else if (cfg.bpp == BPP_16)
        begin
            fmt_r = FMT_565_R;
            fmt_g = FMT_565_G;
            fmt_b = FMT_565_B;
        end
        else
        begin
            fmt_r = FMT_888_R;
            fmt_g = FMT_888_G;
            fmt_b = FMT_888_B;
        end

        priority if (cfg.bpp == BPP_1)
            pal_idx = {7'd0, byte0[3'd7 - s1_sub_reg]};
        else if (cfg.bpp == BPP_4)
            pal_idx = s1_sub_reg[0] ? {4'd0, byte0[3:0]} : {4'd0, byte0[7:4]};
        else
            pal_idx = byte0;
    end

    assign ram_we = s1_valid_reg && (s1_cmd_reg == CMD_LOAD) && ready2
                    && ({1'b0, s1_slot_reg} < PAL_LIMIT);
    assign ram_re = s1_valid_reg && (s1_cmd_reg == CMD_CONVERT) && ready2;

    bpuck_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_slot_reg[PAL_AW-1:0]),
        .wdata (s1_rgb_reg),
        .re    (ram_re),
        .raddr (pal_idx[PAL_AW-1:0]),
        .rdata (ram_rdata)
    );

    // stage 2 payload
    logic        s2_err_reg, s2_pal_reg, s2_oob_reg;
    logic [31:0] s2_mr_reg, s2_mg_reg, s2_mb_reg;
    logic [4:0]  s2_lr_reg, s2_lg_reg, s2_lb_reg;
    logic [5:0]  s2_sr_reg, s2_sg_reg, s2_sb_reg;

    // stage 3 payload
    logic        s3_err_reg, s3_pal_reg;
    logic [23:0] s3_pal_rgb_reg;
    logic [31:0] s3_br_reg, s3_bg_reg, s3_bb_reg;
    logic [5:0]  s3_sr_reg, s3_sg_reg, s3_sb_reg;

    // stage 4 output register
    logic [7:0]  s4_red_reg, s4_grn_reg, s4_blu_reg;
    logic        s4_we_reg, s4_status_reg;

    // stage 3 to 4 result select
    logic [7:0]  r_next, g_next, b_next;
    logic        key_hit;

    always_comb
    begin
        priority if (s3_err_reg)
        begin
            r_next = 8'd0;
            g_next = 8'd0;
            b_next = 8'd0;
        end
        else if (s3_pal_reg)
        begin
            r_next = s3_pal_rgb_reg[23:16];
            g_next = s3_pal_rgb_reg[15:8];
            b_next = s3_pal_rgb_reg[7:0];
        end
        else
        begin
            r_next = scale8(s3_br_reg, s3_sr_reg);
            g_next = scale8(s3_bg_reg, s3_sg_reg);
            b_next = scale8(s3_bb_reg, s3_sb_reg);
        end
    end

    assign key_hit = cfg.key_en && (r_next == 8'h00) && (g_next == 8'hff) && (b_next == 8'h00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                s1_valid_reg <= s_axis_tvalid;
            // drop load items once the palette is written
            if (ready2)
                s2_valid_reg <= s1_valid_reg && (s1_cmd_reg == CMD_CONVERT);
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            s1_cmd_reg  <= s_axis_tuser[0];
            s1_word_reg <= s_axis_tdata[31:0];
            s1_sub_reg  <= s_axis_tdata[34:32];
            s1_slot_reg <= s_axis_tdata[42:35];
            s1_rgb_reg  <= {s_axis_tdata[50:43], s_axis_tdata[58:51], s_axis_tdata[66:59]};
        end
        if (ready2)
        begin
            s2_err_reg <= !(comp_ok && depth_ok);
            s2_pal_reg <= pal_mode;
            s2_oob_reg <= !({1'b0, pal_idx} < PAL_LIMIT);
            s2_mr_reg  <= c_word & fmt_r.mask;
            s2_mg_reg  <= c_word & fmt_g.mask;
            s2_mb_reg  <= c_word & fmt_b.mask;
            s2_lr_reg  <= fmt_r.low;
            s2_lg_reg  <= fmt_g.low;
            s2_lb_reg  <= fmt_b.low;
            s2_sr_reg  <= fmt_r.span;
            s2_sg_reg  <= fmt_g.span;
            s2_sb_reg  <= fmt_b.span;
        end
        if (ready3)
        begin
            s3_err_reg     <= s2_err_reg;
            s3_pal_reg     <= s2_pal_reg;
            s3_pal_rgb_reg <= s2_oob_reg ? 24'd0 : ram_rdata;
            s3_br_reg      <= s2_mr_reg >> s2_lr_reg;
            s3_bg_reg      <= s2_mg_reg >> s2_lg_reg;
            s3_bb_reg      <= s2_mb_reg >> s2_lb_reg;
            s3_sr_reg      <= s2_sr_reg;
            s3_sg_reg      <= s2_sg_reg;
            s3_sb_reg      <= s2_sb_reg;
        end
        if (ready4)
        begin
            s4_red_reg    <= r_next;
            s4_grn_reg    <= g_next;
            s4_blu_reg    <= b_next;
            s4_we_reg     <= !s3_err_reg && !key_hit;
            s4_status_reg <= s3_err_reg;
        end
    end

    assign m_axis_tvalid = s4_valid_reg;
    assign m_axis_tdata  = {s4_blu_reg, s4_grn_reg, s4_red_reg};
    assign m_axis_tuser  = {s4_status_reg, s4_we_reg};

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output free");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tdata == 24'd0))
        else $error("error result not cleared");

    a_key_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1] && !m_axis_tuser[0])
            |-> (cfg.key_en && m_axis_tdata == 24'h00ff00))
        else $error("write suppressed without key match");

    a_load_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> !s2_valid_reg)
        else $error("load item entered result path");

endmodule
